[rtl/scdec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scdec_pkg
// Shared constants, types and the bit-timing preset table of the serial CAN
// ASCII command decoder.
// ----------------------------------------------------------------------------
package scdec_pkg;

  // Line store geometry.
  localparam int LINE_BYTES = 22;
  localparam int IDX_W      = $clog2(LINE_BYTES);
  // Read positions run past the end of the line for long frame lines.
  localparam int POS_W      = $clog2(LINE_BYTES + 32);

  // Control characters and command letters.
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_BS   = 8'h08;
  localparam logic [7:0] CHR_NUL  = 8'h00;
  localparam logic [7:0] CHR_S    = 8'h53;
  localparam logic [7:0] CHR_O    = 8'h4F;
  localparam logic [7:0] CHR_C    = 8'h43;
  localparam logic [7:0] CHR_V    = 8'h56;
  localparam logic [7:0] CHR_N    = 8'h4E;
  localparam logic [7:0] CHR_STD  = 8'h74;  // 't'
  localparam logic [7:0] CHR_EXT  = 8'h54;  // 'T'
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_THREE = 8'h33;

  // Result kinds.
  localparam logic [3:0] KIND_FRAME     = 4'd0;
  localparam logic [3:0] KIND_TIMING    = 4'd1;
  localparam logic [3:0] KIND_OPEN      = 4'd2;
  localparam logic [3:0] KIND_CLOSE     = 4'd3;
  localparam logic [3:0] KIND_VERSION   = 4'd4;
  localparam logic [3:0] KIND_SERIAL    = 4'd5;
  localparam logic [3:0] KIND_BELL      = 4'd6;
  localparam logic [3:0] KIND_REJECTED  = 4'd7;
  localparam logic [3:0] KIND_BAD_SPEED = 4'd8;

  // Identifier limits and length limit.
  localparam logic [31:0] STD_ID_MAX = 32'h0000_07FF;
  localparam logic [31:0] EXT_ID_MAX = 32'h1FFF_FFFF;
  localparam logic [3:0]  MAX_LEN    = 4'd8;

  typedef struct packed {
    logic [7:0] prescaler;
    logic [4:0] segment_one;
    logic [3:0] segment_two;
    logic [2:0] jump_width;
  } timing_t;

  typedef struct packed {
    logic        is_hex;
    logic [3:0]  nibble;
    logic [31:0] acc;
    logic        stop;
  } hex_res_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        extended_id;
    logic [28:0] identifier;
    logic [3:0]  length;
    logic [31:0] data_low;
    logic [31:0] data_high;
    logic [1:0]  speed_preset;
    logic [7:0]  prescaler;
    logic [4:0]  segment_one;
    logic [3:0]  segment_two;
    logic [2:0]  jump_width;
  } res_t;

  function automatic timing_t preset_timing(input logic [1:0] sel);
    timing_t t;
    case (sel)
      2'd0:    t = '{prescaler: 8'd104, segment_one: 5'd14, segment_two: 4'd8,
                     jump_width: 3'd4};
      2'd1:    t = '{prescaler: 8'd80, segment_one: 5'd12, segment_two: 4'd8,
                     jump_width: 3'd4};
      2'd2:    t = '{prescaler: 8'd8, segment_one: 5'd15, segment_two: 4'd4,
                     jump_width: 3'd3};
      default: t = '{prescaler: 8'd10, segment_one: 5'd7, segment_two: 4'd5,
                     jump_width: 3'd4};
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/scdec_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scdec_ifs
// Valid/ready channels of the decoder: received bytes in, decoded requests out.
// ----------------------------------------------------------------------------
interface scdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scdec_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic        extended_id;
  logic [28:0] identifier;
  logic [3:0]  length;
  logic [31:0] data_low;
  logic [31:0] data_high;
  logic [1:0]  speed_preset;
  logic [7:0]  prescaler;
  logic [4:0]  segment_one;
  logic [3:0]  segment_two;
  logic [2:0]  jump_width;

  modport source (output valid, output kind, output extended_id, output identifier,
                  output length, output data_low, output data_high,
                  output speed_preset, output prescaler, output segment_one,
                  output segment_two, output jump_width, input ready);
  modport sink   (input valid, input kind, input extended_id, input identifier,
                  input length, input data_low, input data_high,
                  input speed_preset, input prescaler, input segment_one,
                  input segment_two, input jump_width, output ready);
endinterface
`default_nettype wire

[rtl/scdec_hex_acc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scdec_hex_acc
// Shared hex digit unit: classifies one character and shifts its nibble into
// the running field value until the first non-hex character.
// ----------------------------------------------------------------------------
module scdec_hex_acc import scdec_pkg::*; (
  input  logic [7:0]  chr,
  input  logic [31:0] acc_in,
  input  logic        stop_in,
  output hex_res_t    res
);

  always_comb begin
    res.is_hex = 1'b1;
    res.nibble = 4'd0;
    if (chr >= 8'h30 && chr <= 8'h39) begin
      res.nibble = 4'(chr - 8'h30);
    end else if (chr >= 8'h41 && chr <= 8'h46) begin
      res.nibble = 4'(chr - 8'h37);
    end else if (chr >= 8'h61 && chr <= 8'h66) begin
      res.nibble = 4'(chr - 8'h57);
    end else begin
      res.is_hex = 1'b0;
    end
    res.stop = stop_in | ~res.is_hex;
    res.acc  = res.stop ? acc_in : {acc_in[27:0], res.nibble};
  end

endmodule
`default_nettype wire

[rtl/scdec_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scdec_line_store
// Line buffer with write index: stores bytes, handles backspace, overflow and
// the line terminator, and serves one read position per cycle.
// ----------------------------------------------------------------------------
module scdec_line_store import scdec_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [7:0]       wr_byte,
  input  logic [POS_W-1:0] rd_pos,
  output logic [7:0]       rd_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_BYTES - 1);
  localparam logic [POS_W-1:0] LINE_POS = POS_W'(LINE_BYTES);

  logic [7:0]       store_r [LINE_BYTES];
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
      idx_r <= '0;
    end else if (wr_en) begin
      if (wr_byte == CHR_CR) begin
        store_r[idx_r] <= CHR_NUL;
        idx_r          <= '0;
      end else if (wr_byte == CHR_BS) begin
        if (idx_r != '0) begin
          idx_r <= idx_r - 1'b1;
        end
      end else begin
        store_r[idx_r] <= wr_byte;
        idx_r          <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Positions beyond the buffer read as zero.
  assign rd_data = (rd_pos < LINE_POS) ? store_r[rd_pos[IDX_W-1:0]] : 8'h00;

endmodule
`default_nettype wire

[rtl/serial_can_ascii_command_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_can_ascii_command_decoder_top
// Serial CAN ASCII command decoder: collects received bytes into a line and
// decodes each completed line into one request.
// ----------------------------------------------------------------------------
// A received byte other than carriage return is accepted while idle and
// only updates the line buffer. A carriage return starts a decode that walks
// the stored line one character per cycle through a single shared hex digit
// unit, and the input is not ready until the decode has finished. A decoded
// request waits in an output register; when the previous request has not
// been taken yet, the decode holds in its final step until the register is
// free. The line buffer is cleared by reset itself, so no clearing pass
// follows reset. An empty line produces no request.
// ----------------------------------------------------------------------------
module serial_can_ascii_command_decoder_top import scdec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  scdec_in_if.sink     in_ch,
  scdec_out_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_ID    = 3'd3;
  localparam logic [2:0] ST_LEN   = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             stop_r, stop_nxt;
  logic [63:0]      data_r, data_nxt;
  res_t             work_r, work_nxt;
  res_t             out_r, out_nxt;
  logic             out_valid_r;

  logic             in_take;
  logic [7:0]       rd_data;
  hex_res_t         hex;
  timing_t          timing;
  logic [3:0]       id_last;
  logic [3:0]       len_digit;
  logic [4:0]       data_last;
  logic             out_free;
  logic             out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid & in_ch.ready;
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign out_load    = (state_r == ST_OUT) & out_free;

  scdec_line_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_take),
    .wr_byte (in_ch.rx_byte),
    .rd_pos  (pos_r),
    .rd_data (rd_data)
  );

  // The one hex unit serves identifier, length and data digits alike.
  scdec_hex_acc u_hex (
    .chr     (rd_data),
    .acc_in  (acc_r),
    .stop_in (stop_r),
    .res     (hex)
  );

  assign timing    = preset_timing(rd_data[1:0]);
  assign id_last   = work_r.extended_id ? 4'd7 : 4'd2;
  assign len_digit = hex.is_hex ? hex.nibble : 4'd0;
  assign data_last = 5'({work_r.length, 1'b0} - 5'd1);

  // Decode sequencer: one stored character per cycle.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    stop_nxt  = stop_r;
    data_nxt  = data_r;
    work_nxt  = work_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && in_ch.rx_byte == CHR_CR) begin
          state_nxt = ST_FIRST;
          pos_nxt   = '0;
          work_nxt  = '0;
          data_nxt  = '0;
        end
      end
      ST_FIRST: begin
        pos_nxt  = POS_W'(1);
        cnt_nxt  = 4'd0;
        acc_nxt  = 32'd0;
        stop_nxt = 1'b0;
        unique case (rd_data)
          CHR_NUL: state_nxt = ST_IDLE;
          CHR_S:   state_nxt = ST_SEL;
          CHR_O: begin
            work_nxt.kind = KIND_OPEN;
            state_nxt     = ST_OUT;
          end
          CHR_C: begin
            work_nxt.kind = KIND_CLOSE;
            state_nxt     = ST_OUT;
          end
          CHR_V: begin
            work_nxt.kind = KIND_VERSION;
            state_nxt     = ST_OUT;
          end
          CHR_N: begin
            work_nxt.kind = KIND_SERIAL;
            state_nxt     = ST_OUT;
          end
          CHR_STD: begin
            work_nxt.extended_id = 1'b0;
            state_nxt            = ST_ID;
          end
          CHR_EXT: begin
            work_nxt.extended_id = 1'b1;
            state_nxt            = ST_ID;
          end
          default: begin
            work_nxt.kind = KIND_BELL;
            state_nxt     = ST_OUT;
          end
        endcase
      end
      ST_SEL: begin
        if (rd_data >= CHR_ZERO && rd_data <= CHR_THREE) begin
          work_nxt.kind         = KIND_TIMING;
          work_nxt.speed_preset = rd_data[1:0];
          work_nxt.prescaler    = timing.prescaler;
          work_nxt.segment_one  = timing.segment_one;
          work_nxt.segment_two  = timing.segment_two;
          work_nxt.jump_width   = timing.jump_width;
        end else begin
          work_nxt.kind = KIND_BAD_SPEED;
        end
        state_nxt = ST_OUT;
      end
      ST_ID: begin
        acc_nxt  = hex.acc;
        stop_nxt = hex.stop;
        pos_nxt  = pos_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == id_last) begin
          stop_nxt  = 1'b0;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        pos_nxt  = pos_r + 1'b1;
        cnt_nxt  = 4'd0;
        acc_nxt  = 32'd0;
        stop_nxt = 1'b0;
        if (len_digit > MAX_LEN ||
            acc_r > (work_r.extended_id ? EXT_ID_MAX : STD_ID_MAX)) begin
          work_nxt.kind = KIND_REJECTED;
          state_nxt     = ST_OUT;
        end else begin
          work_nxt.kind       = KIND_FRAME;
          work_nxt.identifier = acc_r[28:0];
          work_nxt.length     = len_digit;
          state_nxt           = (len_digit == 4'd0) ? ST_OUT : ST_DATA;
        end
      end
      ST_DATA: begin
        pos_nxt  = pos_r + 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        acc_nxt  = hex.acc;
        stop_nxt = hex.stop;
        // The second digit of a pair closes the byte.
        if (cnt_r[0]) begin
          data_nxt[{cnt_r[3:1], 3'b000} +: 8] = hex.acc[7:0];
          acc_nxt  = 32'd0;
          stop_nxt = 1'b0;
        end
        if ({1'b0, cnt_r} == data_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The finished request with its collected data bytes.
  always_comb begin
    out_nxt           = work_r;
    out_nxt.data_low  = data_r[31:0];
    out_nxt.data_high = data_r[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    stop_r <= stop_nxt;
    data_r <= data_nxt;
    work_r <= work_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.extended_id  = out_r.extended_id;
  assign out_ch.identifier   = out_r.identifier;
  assign out_ch.length       = out_r.length;
  assign out_ch.data_low     = out_r.data_low;
  assign out_ch.data_high    = out_r.data_high;
  assign out_ch.speed_preset = out_r.speed_preset;
  assign out_ch.prescaler    = out_r.prescaler;
  assign out_ch.segment_one  = out_r.segment_one;
  assign out_ch.segment_two  = out_r.segment_two;
  assign out_ch.jump_width   = out_r.jump_width;

  // A carriage return always starts a decode, so the input closes next cycle.
  a_cr_starts_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_ch.rx_byte == CHR_CR) |=> !in_ch.ready)
    else $error("carriage return did not start a decode");

  // A new request only appears out of the final decode step.
  a_request_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("request raised outside the final decode step");

  // A delivered frame never exceeds the data length limit.
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_FRAME) |-> out_r.length <= MAX_LEN)
    else $error("frame request with length above limit");

  // A standard frame keeps its identifier within 11 bits.
  a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_FRAME && !out_r.extended_id)
      |-> out_r.identifier[28:11] == '0)
    else $error("standard frame identifier above 11 bits");

endmodule
`default_nettype wire
